// ===== rtl/qsmp_pkg.sv =====
// Shared types and codes for the middle-pivot quicksort block.
// Used by the controller, the datapath, the top level and the port checker.
package qsmp_pkg;

    // Input transaction: one element of the set, with the end-of-set mark.
    typedef struct packed {
        logic signed [31:0] value;
        logic               last;
    } t_in;

    // Output transaction: one element in ascending order.
    typedef struct packed {
        logic signed [31:0] sorted_value;
        logic               final_res;
        logic               overflowed;
    } t_out;

    // Element store address selects.
    localparam logic [2:0] A_CNT = 3'd0;
    localparam logic [2:0] A_MID = 3'd1;
    localparam logic [2:0] A_HI  = 3'd2;
    localparam logic [2:0] A_J   = 3'd3;
    localparam logic [2:0] A_I   = 3'd4;
    localparam logic [2:0] A_K   = 3'd5;

    // Element store write data selects.
    localparam logic [1:0] D_IN  = 2'd0;
    localparam logic [1:0] D_RD  = 2'd1;
    localparam logic [1:0] D_VJ  = 2'd2;
    localparam logic [1:0] D_PIV = 2'd3;

    // Range stack operations.
    localparam logic [2:0] SK_NONE  = 3'd0;
    localparam logic [2:0] SK_INIT  = 3'd1;
    localparam logic [2:0] SK_POP   = 3'd2;
    localparam logic [2:0] SK_PUSHL = 3'd3;
    localparam logic [2:0] SK_PUSHR = 3'd4;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       load;
        logic       st_re;
        logic [2:0] st_ra;
        logic       st_we;
        logic [2:0] st_wa;
        logic [1:0] st_wd;
        logic [2:0] sk_op;
        logic       range_ld;
        logic       piv_ld;
        logic       vj_ld;
        logic       ij_init;
        logic       i_inc;
        logic       j_inc;
        logic       k_clr;
        logic       k_inc;
        logic       out_ld;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic sp_zero;
        logic rng_skip;
        logic j_eq_hi;
        logic i_eq_j;
        logic i_eq_hi;
        logic le_piv;
        logic push_l_ok;
        logic push_r_ok;
        logic k_last;
        logic out_free;
    } t_sts;

endpackage

// ===== rtl/qsmp_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module qsmp_ram #(
    parameter int W = 32,
    parameter int D = 64,
    localparam int AW = $clog2(D)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [W-1:0]  i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [W-1:0]  o_rdata
);

    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port; the data holds until the next read.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/qsmp_ctrl.sv =====
// Sequencer for loading, partitioning and emitting the sorted set.
// Depends on qsmp_pkg for the command and status structs and select codes.
module qsmp_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            i_in_last,
    output logic            o_in_ready,
    input  qsmp_pkg::t_sts  i_sts,
    output qsmp_pkg::t_cmd  o_cmd
);
    import qsmp_pkg::*;

    localparam logic [4:0] S_LOAD  = 5'd0;
    localparam logic [4:0] S_INIT  = 5'd1;
    localparam logic [4:0] S_POP   = 5'd2;
    localparam logic [4:0] S_RANGE = 5'd3;
    localparam logic [4:0] S_MRD   = 5'd4;
    localparam logic [4:0] S_HRD   = 5'd5;
    localparam logic [4:0] S_MWR   = 5'd6;
    localparam logic [4:0] S_HWR   = 5'd7;
    localparam logic [4:0] S_JRD   = 5'd8;
    localparam logic [4:0] S_JCMP  = 5'd9;
    localparam logic [4:0] S_IWR   = 5'd10;
    localparam logic [4:0] S_JWR   = 5'd11;
    localparam logic [4:0] S_FRD   = 5'd12;
    localparam logic [4:0] S_FW1   = 5'd13;
    localparam logic [4:0] S_FW2   = 5'd14;
    localparam logic [4:0] S_PUSHL = 5'd15;
    localparam logic [4:0] S_PUSHR = 5'd16;
    localparam logic [4:0] S_ERD   = 5'd17;
    localparam logic [4:0] S_EOUT  = 5'd18;

    logic [4:0] r_state;
    logic [4:0] n_state;
    t_cmd       w_cmd;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands.
    always_comb begin
        n_state = r_state;
        w_cmd   = '0;
        w_cmd.st_ra = A_K;
        w_cmd.st_wa = A_CNT;
        w_cmd.st_wd = D_IN;
        w_cmd.sk_op = SK_NONE;
        case (r_state)
            S_LOAD: begin
                if (i_in_valid) begin
                    w_cmd.load = 1'b1;
                    if (i_in_last) begin
                        n_state = S_INIT;
                    end
                end
            end
            S_INIT: begin
                w_cmd.sk_op = SK_INIT;
                w_cmd.k_clr = 1'b1;
                n_state     = S_POP;
            end
            S_POP: begin
                if (i_sts.sp_zero) begin
                    n_state = S_ERD;
                end else begin
                    w_cmd.sk_op = SK_POP;
                    n_state     = S_RANGE;
                end
            end
            S_RANGE: begin
                w_cmd.range_ld = 1'b1;
                n_state = i_sts.rng_skip ? S_POP : S_MRD;
            end
            S_MRD: begin
                w_cmd.st_re = 1'b1;
                w_cmd.st_ra = A_MID;
                n_state     = S_HRD;
            end
            S_HRD: begin
                w_cmd.piv_ld = 1'b1;
                w_cmd.st_re  = 1'b1;
                w_cmd.st_ra  = A_HI;
                n_state      = S_MWR;
            end
            S_MWR: begin
                w_cmd.st_we = 1'b1;
                w_cmd.st_wa = A_MID;
                w_cmd.st_wd = D_RD;
                n_state     = S_HWR;
            end
            S_HWR: begin
                w_cmd.st_we   = 1'b1;
                w_cmd.st_wa   = A_HI;
                w_cmd.st_wd   = D_PIV;
                w_cmd.ij_init = 1'b1;
                n_state       = S_JRD;
            end
            S_JRD: begin
                if (i_sts.j_eq_hi) begin
                    n_state = S_FRD;
                end else begin
                    w_cmd.st_re = 1'b1;
                    w_cmd.st_ra = A_J;
                    n_state     = S_JCMP;
                end
            end
            S_JCMP: begin
                w_cmd.vj_ld = 1'b1;
                if (i_sts.le_piv && i_sts.i_eq_j) begin
                    w_cmd.i_inc = 1'b1;
                    w_cmd.j_inc = 1'b1;
                    n_state     = S_JRD;
                end else if (i_sts.le_piv) begin
                    w_cmd.st_re = 1'b1;
                    w_cmd.st_ra = A_I;
                    n_state     = S_IWR;
                end else begin
                    w_cmd.j_inc = 1'b1;
                    n_state     = S_JRD;
                end
            end
            S_IWR: begin
                w_cmd.st_we = 1'b1;
                w_cmd.st_wa = A_J;
                w_cmd.st_wd = D_RD;
                n_state     = S_JWR;
            end
            S_JWR: begin
                w_cmd.st_we = 1'b1;
                w_cmd.st_wa = A_I;
                w_cmd.st_wd = D_VJ;
                w_cmd.i_inc = 1'b1;
                w_cmd.j_inc = 1'b1;
                n_state     = S_JRD;
            end
            S_FRD: begin
                if (i_sts.i_eq_hi) begin
                    n_state = S_PUSHL;
                end else begin
                    w_cmd.st_re = 1'b1;
                    w_cmd.st_ra = A_I;
                    n_state     = S_FW1;
                end
            end
            S_FW1: begin
                w_cmd.st_we = 1'b1;
                w_cmd.st_wa = A_HI;
                w_cmd.st_wd = D_RD;
                n_state     = S_FW2;
            end
            S_FW2: begin
                w_cmd.st_we = 1'b1;
                w_cmd.st_wa = A_I;
                w_cmd.st_wd = D_PIV;
                n_state     = S_PUSHL;
            end
            S_PUSHL: begin
                if (i_sts.push_l_ok) begin
                    w_cmd.sk_op = SK_PUSHL;
                end
                n_state = S_PUSHR;
            end
            S_PUSHR: begin
                if (i_sts.push_r_ok) begin
                    w_cmd.sk_op = SK_PUSHR;
                end
                n_state = S_POP;
            end
            S_ERD: begin
                w_cmd.st_re = 1'b1;
                w_cmd.st_ra = A_K;
                n_state     = S_EOUT;
            end
            S_EOUT: begin
                if (i_sts.out_free) begin
                    w_cmd.out_ld = 1'b1;
                    if (i_sts.k_last) begin
                        n_state = S_LOAD;
                    end else begin
                        w_cmd.k_inc = 1'b1;
                        n_state     = S_ERD;
                    end
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    assign o_in_ready = (r_state == S_LOAD);
    assign o_cmd      = w_cmd;

endmodule

// ===== rtl/qsmp_dp.sv =====
// Datapath: element store, range stack, partition indexes and output register.
// Depends on qsmp_pkg and qsmp_ram.
module qsmp_dp #(
    parameter int MAX_ELEMENTS = 64
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  qsmp_pkg::t_cmd  i_cmd,
    output qsmp_pkg::t_sts  o_sts,
    input  qsmp_pkg::t_in   i_in_data,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output qsmp_pkg::t_out  o_out_data
);
    import qsmp_pkg::*;

    localparam int IW = $clog2(MAX_ELEMENTS);
    localparam int CW = IW + 1;
    localparam int SW = 2 * IW;
    localparam logic [CW-1:0] CNT_MAX = CW'(MAX_ELEMENTS);
    localparam logic [CW-1:0] ONE     = CW'(1);
    localparam logic [CW-1:0] TWO     = CW'(2);

    logic [CW-1:0] r_cnt;
    logic          r_drop;
    logic [IW-1:0] r_lo;
    logic [IW-1:0] r_hi;
    logic [IW-1:0] r_i;
    logic [IW-1:0] r_j;
    logic [IW-1:0] r_k;
    logic [31:0]   r_piv;
    logic [31:0]   r_vj;
    logic [CW-1:0] r_sp;
    logic          r_out_vld;
    t_out          r_out;

    logic [31:0]   w_st_rdata;
    logic [IW-1:0] w_st_raddr;
    logic [IW-1:0] w_st_waddr;
    logic [31:0]   w_st_wdata;
    logic          w_st_we;
    logic          w_room;

    logic [SW-1:0] w_sk_rdata;
    logic [SW-1:0] w_sk_wdata;
    logic [IW-1:0] w_sk_waddr;
    logic [IW-1:0] w_sk_raddr;
    logic          w_sk_we;
    logic          w_sk_re;
    logic          w_sk_room;
    logic [IW-1:0] w_rd_lo;
    logic [IW-1:0] w_rd_hi;

    logic [CW-1:0] w_span;
    logic [CW-1:0] w_mid_full;
    logic [IW-1:0] w_mid;
    logic [CW-1:0] w_n_m1;
    logic          w_k_last;
    logic          w_out_free;

    // Middle index of the current range: lo + size / 2.
    assign w_span     = {1'b0, r_hi} - {1'b0, r_lo} + ONE;
    assign w_mid_full = {1'b0, r_lo} + (w_span >> 1);
    assign w_mid      = w_mid_full[IW-1:0];
    assign w_n_m1     = r_cnt - ONE;
    assign w_room     = (r_cnt < CNT_MAX);

    // Element store address and data selection.
    always_comb begin
        case (i_cmd.st_ra)
            A_MID:   w_st_raddr = w_mid;
            A_HI:    w_st_raddr = r_hi;
            A_J:     w_st_raddr = r_j;
            A_I:     w_st_raddr = r_i;
            default: w_st_raddr = r_k;
        endcase
        case (i_cmd.st_wa)
            A_MID:   w_st_waddr = w_mid;
            A_HI:    w_st_waddr = r_hi;
            A_J:     w_st_waddr = r_j;
            A_I:     w_st_waddr = r_i;
            default: w_st_waddr = r_cnt[IW-1:0];
        endcase
        case (i_cmd.st_wd)
            D_RD:    w_st_wdata = w_st_rdata;
            D_VJ:    w_st_wdata = r_vj;
            D_PIV:   w_st_wdata = r_piv;
            default: w_st_wdata = i_in_data.value;
        endcase
    end

    // Loading writes only while the store has room.
    assign w_st_we = i_cmd.st_we || (i_cmd.load && w_room);

    qsmp_ram #(.W(32), .D(MAX_ELEMENTS)) u_store (
        .i_clk   (i_clk),
        .i_we    (w_st_we),
        .i_waddr (w_st_waddr),
        .i_wdata (w_st_wdata),
        .i_re    (i_cmd.st_re),
        .i_raddr (w_st_raddr),
        .o_rdata (w_st_rdata)
    );

    function automatic logic [IW-1:0] w_n_sp_m1(input logic [CW-1:0] sp);
        logic [CW-1:0] t;
        t = sp - ONE;
        return t[IW-1:0];
    endfunction

    // Range stack: entries hold {lo, hi} with inclusive bounds.
    assign w_sk_room  = (r_sp < CNT_MAX);
    assign w_sk_raddr = w_n_sp_m1(r_sp);
    assign w_sk_re    = (i_cmd.sk_op == SK_POP);
    assign w_rd_lo    = w_sk_rdata[SW-1:IW];
    assign w_rd_hi    = w_sk_rdata[IW-1:0];

    always_comb begin
        w_sk_we    = 1'b0;
        w_sk_waddr = r_sp[IW-1:0];
        w_sk_wdata = {r_lo, r_hi};
        case (i_cmd.sk_op)
            SK_INIT: begin
                w_sk_we    = (r_cnt >= TWO);
                w_sk_waddr = '0;
                w_sk_wdata = {{IW{1'b0}}, w_n_m1[IW-1:0]};
            end
            SK_PUSHL: begin
                w_sk_we    = w_sk_room;
                w_sk_wdata = {r_lo, r_i - IW'(1)};
            end
            SK_PUSHR: begin
                w_sk_we    = w_sk_room;
                w_sk_wdata = {r_i + IW'(1), r_hi};
            end
            default: begin
                w_sk_we = 1'b0;
            end
        endcase
    end

    qsmp_ram #(.W(SW), .D(MAX_ELEMENTS)) u_stack (
        .i_clk   (i_clk),
        .i_we    (w_sk_we),
        .i_waddr (w_sk_waddr),
        .i_wdata (w_sk_wdata),
        .i_re    (w_sk_re),
        .i_raddr (w_sk_raddr),
        .o_rdata (w_sk_rdata)
    );

    // Stack depth.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sp <= '0;
        end else begin
            case (i_cmd.sk_op)
                SK_INIT:  r_sp <= (r_cnt >= TWO) ? ONE : '0;
                SK_POP:   r_sp <= r_sp - ONE;
                SK_PUSHL: r_sp <= w_sk_room ? r_sp + ONE : r_sp;
                SK_PUSHR: r_sp <= w_sk_room ? r_sp + ONE : r_sp;
                default:  r_sp <= r_sp;
            endcase
        end
    end

    // Element count and overflow flag; both clear once the set is emitted.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_drop <= 1'b0;
        end else if (i_cmd.out_ld && w_k_last) begin
            r_cnt  <= '0;
            r_drop <= 1'b0;
        end else if (i_cmd.load) begin
            if (w_room) begin
                r_cnt <= r_cnt + ONE;
            end else begin
                r_drop <= 1'b1;
            end
        end
    end

    // Range bounds, partition indexes, pivot and scanned value.
    always_ff @(posedge i_clk) begin
        if (i_cmd.range_ld) begin
            r_lo <= w_rd_lo;
            r_hi <= w_rd_hi;
        end
        if (i_cmd.piv_ld) begin
            r_piv <= w_st_rdata;
        end
        if (i_cmd.vj_ld) begin
            r_vj <= w_st_rdata;
        end
        if (i_cmd.ij_init) begin
            r_i <= r_lo;
        end else if (i_cmd.i_inc) begin
            r_i <= r_i + IW'(1);
        end
        if (i_cmd.ij_init) begin
            r_j <= r_lo;
        end else if (i_cmd.j_inc) begin
            r_j <= r_j + IW'(1);
        end
        if (i_cmd.k_clr) begin
            r_k <= '0;
        end else if (i_cmd.k_inc) begin
            r_k <= r_k + IW'(1);
        end
    end

    // Output register.
    assign w_k_last   = ({1'b0, r_k} == w_n_m1);
    assign w_out_free = !r_out_vld || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.out_ld) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_ld) begin
            r_out.sorted_value <= w_st_rdata;
            r_out.final_res    <= w_k_last;
            r_out.overflowed   <= r_drop;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    // Status toward the controller.
    always_comb begin
        o_sts.sp_zero   = (r_sp == '0);
        o_sts.rng_skip  = (w_rd_lo >= w_rd_hi) || ({1'b0, w_rd_hi} >= r_cnt);
        o_sts.j_eq_hi   = (r_j == r_hi);
        o_sts.i_eq_j    = (r_i == r_j);
        o_sts.i_eq_hi   = (r_i == r_hi);
        o_sts.le_piv    = ($signed(w_st_rdata) <= $signed(r_piv));
        o_sts.push_l_ok = ({1'b0, r_i} > ({1'b0, r_lo} + ONE));
        o_sts.push_r_ok = (({1'b0, r_i} + ONE) < {1'b0, r_hi});
        o_sts.k_last    = w_k_last;
        o_sts.out_free  = w_out_free;
    end

endmodule

// ===== rtl/quicksort_middle_pivot_top.sv =====
// Quicksort block with middle-element pivot: elements load one per transaction,
// one cycle each, until a transaction marked last; elements beyond MAX_ELEMENTS
// are dropped and every result of that set is marked overflowed. The set is then
// sorted in place in a single-read, single-write element RAM, with pending
// ranges on a stack RAM. The element RAM port paces the work: each element scanned
// in a partition takes a read and a compare, plus two writes when it is swapped,
// and each range adds a pop, a pivot swap and its pushes. Results then leave in
// ascending signed order, each read from the element RAM before it enters the
// output register, the last one marked final_res; the input is not ready from
// the last transaction until the final result is in the output register. No
// clearing pass follows reset.
// Depends on qsmp_pkg, qsmp_ctrl, qsmp_dp and qsmp_ram.
module quicksort_middle_pivot_top #(
    parameter int MAX_ELEMENTS = 64
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  qsmp_pkg::t_in  i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output qsmp_pkg::t_out o_out_data
);
    import qsmp_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    // Sequencer.
    qsmp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_last  (i_in_data.last),
        .o_in_ready (o_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // Storage and arithmetic.
    qsmp_dp #(.MAX_ELEMENTS(MAX_ELEMENTS)) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

// ===== rtl/qsmp_chk.sv =====
// Port-level checker for the quicksort block, bound to the top level.
// Depends on qsmp_pkg for the transaction types.
module qsmp_chk (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_in_valid,
    input logic           o_in_ready,
    input qsmp_pkg::t_in  i_in_data,
    input logic           o_out_valid,
    input logic           i_out_ready,
    input qsmp_pkg::t_out o_out_data
);

    // A stalled result holds its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_data)))
        else $error("result changed while stalled");

    // The end of a set stops loading while the set is sorted.
    a_last_stops_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_in_data.last) |=> !o_in_ready)
        else $error("input still ready after the end of a set");

    // While loading, only the final result of the previous set may wait.
    a_load_only_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_in_ready) |-> o_out_data.final_res)
        else $error("non-final result pending while loading");

    // Nothing follows the final result until a new set arrives.
    a_final_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && o_out_data.final_res) |=> !o_out_valid)
        else $error("result after the final one of a set");

    // The overflow flag is the same on every result of a set.
    a_ovf_steady: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.final_res) |=>
        (!o_out_valid || (o_out_data.overflowed == $past(o_out_data.overflowed))))
        else $error("overflow flag changed within a set");

endmodule

bind quicksort_middle_pivot_top qsmp_chk u_qsmp_chk (.*);

// ===== dv/quicksort_middle_pivot_top_tb.sv =====
// Self-checking testbench for quicksort_middle_pivot_top: it streams sets of signed values,
// predicts the ascending output of each set and checks every result transaction.
// Depends on qsmp_pkg and the RTL of the block; it needs no other file.
module quicksort_middle_pivot_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import qsmp_pkg::*;

    localparam int CAPACITY    = 64;
    localparam int IDLE_LIMIT  = 50000;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN       = 40;
    localparam int RAND_ITEMS  = 96;

    typedef logic signed [31:0] t_vals[$];

    // Set model: collects elements and expands each finished set into its sorted results.
    class sort_scoreboard;
        logic signed [31:0] held[$];
        bit                 dropped;
        t_out               awaited[$];
        int                 errors;
        int                 sets_done;
        int                 overflow_sets;
        int                 results_seen;

        function void note_input(t_in item);
            logic signed [31:0] ordered[$];
            t_out               res;
            int                 p;
            if (held.size() < CAPACITY) begin
                held.push_back(item.value);
            end else begin
                dropped = 1'b1;
            end
            if (!item.last) begin
                return;
            end
            // Insertion into an ascending list gives the same order for any tie.
            foreach (held[k]) begin
                p = 0;
                while (p < ordered.size() && ordered[p] <= held[k]) begin
                    p++;
                end
                ordered.insert(p, held[k]);
            end
            foreach (ordered[k]) begin
                res.sorted_value = ordered[k];
                res.final_res    = (k == ordered.size() - 1);
                res.overflowed   = dropped;
                awaited.push_back(res);
            end
            sets_done++;
            if (dropped) begin
                overflow_sets++;
            end
            held.delete();
            dropped = 1'b0;
        endfunction

        function void check_result(t_out got);
            t_out want;
            results_seen++;
            if (awaited.size() == 0) begin
                $error("unexpected result: sorted_value %0d", $signed(got.sorted_value));
                errors++;
                return;
            end
            want = awaited.pop_front();
            if (got.sorted_value !== want.sorted_value) begin
                $error("sorted_value: expected %0d, got %0d",
                       $signed(want.sorted_value), $signed(got.sorted_value));
                errors++;
            end
            if (got.final_res !== want.final_res) begin
                $error("final_res: expected %0b, got %0b", want.final_res, got.final_res);
                errors++;
            end
            if (got.overflowed !== want.overflowed) begin
                $error("overflowed: expected %0b, got %0b", want.overflowed, got.overflowed);
                errors++;
            end
        endfunction

        function int pending();
            return awaited.size();
        endfunction
    endclass

    logic  i_clk;
    logic  i_rst_n;
    logic  i_in_valid;
    logic  o_in_ready;
    t_in   i_in_data;
    logic  o_out_valid;
    logic  i_out_ready;
    t_out  o_out_data;

    sort_scoreboard sb = new();
    int  burst_left;
    int  idle_cycles;
    int  inputs_taken;
    bit  hold_req;
    int  holds_done;

    quicksort_middle_pivot_top #(
        .MAX_ELEMENTS(CAPACITY)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data)
    );

    // Clock generation.
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Monitors sample both channels at the rising edge.
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && o_in_ready) begin
            sb.note_input(i_in_data);
            inputs_taken++;
        end
        if (i_rst_n && o_out_valid && i_out_ready) begin
            sb.check_result(o_out_data);
        end
    end

    // Watchdog on cycles without any transaction.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Watchdog expired with %0d results outstanding.", sb.pending());
            $display("TEST FAILED");
            $finish;
        end
    end

    // Receiver: ready follows a rotating stall pattern that is redrawn now and then.
    // On request it holds off for a long stretch while results are waiting.
    initial begin
        bit [15:0] ready_pat;
        int        pat_pos;
        int        pat_left;
        ready_pat   = 16'hFFFF;
        pat_pos     = 0;
        pat_left    = 0;
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req && o_out_valid) begin
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_req = 1'b0;
                holds_done++;
            end else begin
                if (pat_left == 0) begin
                    case ($urandom_range(0, 3))
                        0:       ready_pat = 16'hFFFF;
                        1:       ready_pat = 16'($urandom);
                        2:       ready_pat = 16'($urandom & $urandom);
                        default: ready_pat = 16'($urandom | $urandom);
                    endcase
                    pat_left = $urandom_range(16, 80);
                end
                pat_left--;
                i_out_ready <= ready_pat[pat_pos];
                pat_pos = (pat_pos + 1) % 16;
            end
        end
    end

    // Offer one element; called and returning at a falling edge. Gaps fall between bursts.
    task automatic send_item(logic signed [31:0] value, logic last);
        t_in item;
        int  gap;
        if (burst_left == 0) begin
            if ($urandom_range(0, 7) == 0) begin
                burst_left = 64;
                gap        = 0;
            end else begin
                burst_left = $urandom_range(1, 16);
                gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
            end
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        item.value  = value;
        item.last   = last;
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        do @(posedge i_clk); while (!o_in_ready);
        burst_left--;
        @(negedge i_clk);
    endtask

    task automatic send_set(t_vals vals);
        foreach (vals[k]) begin
            send_item(vals[k], k == vals.size() - 1);
        end
    endtask

    // Content styles: full range, narrow range with many ties, all equal, runs.
    function automatic t_vals make_set(int n, int mode);
        t_vals              vals;
        logic signed [31:0] base;
        logic signed [31:0] step;
        base = $urandom;
        step = $urandom_range(1, 1000);
        for (int k = 0; k < n; k++) begin
            case (mode)
                0:       vals.push_back($urandom);
                1:       vals.push_back($signed($urandom_range(0, 6)) - 3);
                2:       vals.push_back(base);
                3:       vals.push_back(base + k * step);
                default: vals.push_back(base - k * step);
            endcase
        end
        return vals;
    endfunction

    // Main sequence: reset, directed sets, then random sets.
    initial begin
        t_vals d;
        int    counted;
        int    s;
        int    n;
        int    mode;
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_in_data  = '0;
        burst_left = 0;
        hold_req   = 1'b0;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Single-element sets at both extremes.
        d = '{32'sh8000_0000};
        send_set(d);
        d = '{32'sh7FFF_FFFF};
        send_set(d);
        // Extremes and neighbors of zero mixed together.
        d = '{32'sh7FFF_FFFF, 32'sh8000_0000, 0, -1, 1, 32'sh8000_0001, 32'sh7FFF_FFFE};
        send_set(d);
        // Equal values around the pivot.
        d = '{5, 5, 5, -5, -5};
        send_set(d);
        // Smallest ranges that need a partition, then a descending run.
        d = '{3, -3};
        send_set(d);
        d = '{0, 0};
        send_set(d);
        d = '{60, 50, 40, 30, 20, 10};
        send_set(d);

        // Random sets: mostly small, plus one set of equal values that fills the store
        // (the slow case) and overflows, with its last two elements discarded.
        counted = 0;
        s       = 0;
        while (counted < RAND_ITEMS || s <= 3) begin
            if (s == 1) begin
                n    = CAPACITY + 2;
                mode = 2;
            end else begin
                n    = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 20)
                                                   : $urandom_range(1, 8);
                mode = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 4);
            end
            // The receiver holds off during this set while further items are offered.
            if (s == 3) begin
                hold_req = 1'b1;
            end
            send_set(make_set(n, mode));
            counted += (n > CAPACITY) ? CAPACITY : n;
            s++;
        end
        i_in_valid <= 1'b0;

        while (sb.pending() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN) @(posedge i_clk);

        $display("Covered %0d sets (%0d overflowed, %0d long receiver hold-offs), %0d inputs,",
                 sb.sets_done, sb.overflow_sets, holds_done, inputs_taken);
        $display("and checked %0d sorted results with %0d mismatches.",
                 sb.results_seen, sb.errors);
        if (sb.errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
